// ===== rtl/vgs_pkg.sv =====
// Shared constants, codes and the weight table of the 3x3x3 volume smoother.
// Used by every file of the block but the job queue, and by the bench; depends on nothing.
`default_nettype none
package vgs_pkg;
   localparam int VOX_W      = 8;
   localparam int XREG_W     = 9;
   localparam int YREG_W     = 9;
   localparam int ZREG_W     = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int Z_W        = 13;
   localparam int Z_LIMIT    = 4096;

   localparam int DEF_MAX_ROW  = 256;
   localparam int DEF_MAX_ROWS = 256;

   localparam logic [CSR_IDX_W-1:0] REG_X_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Z_SIZE = 2'd2;

   localparam logic [XREG_W-1:0] RST_X_SIZE = 9'd256;
   localparam logic [YREG_W-1:0] RST_Y_SIZE = 9'd256;
   localparam logic [ZREG_W-1:0] RST_Z_SIZE = 13'd256;

   localparam logic OP_VOXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int WT_W     = 16;
   localparam int PROD_W   = VOX_W + WT_W;
   localparam int ACC_W    = 29;
   localparam int WSUM_W   = 21;
   localparam int QUO_W    = 8;
   localparam int DEN_W    = WSUM_W + QUO_W - 1;
   localparam int QCNT_W   = 3;

   // Q0.16 weights indexed by the number of off-centre axes.
   function automatic logic [WT_W-1:0] gauss_weight(input logic [1:0] d2);
      logic [WT_W-1:0] w;
      unique case (d2)
         2'd0: w = 16'd65535;
         2'd1: w = 16'd55524;
         2'd2: w = 16'd47041;
         default: w = 16'd39855;
      endcase
      return w;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/vgs_if.sv =====
// Handshake channels of the volume smoother: input, result and register write.
// Depends on vgs_pkg for the field widths.
`default_nettype none
interface vgs_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [vgs_pkg::VOX_W-1:0]   voxel;
   modport source (output valid, opcode, voxel, input ready);
   modport sink   (input valid, opcode, voxel, output ready);
endinterface

interface vgs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vgs_pkg::VOX_W-1:0]   smoothed;
   logic                        last_voxel;
   modport source (output valid, smoothed, last_voxel, input ready);
   modport sink   (input valid, smoothed, last_voxel, output ready);
endinterface

interface vgs_csr_if;
   logic                             valid;
   logic                             ready;
   logic [vgs_pkg::CSR_IDX_W-1:0]    index;
   logic [vgs_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/vgs_fifo.sv =====
// Two-entry job queue between the front and the back of the smoother.
// Depends on nothing but its width parameter.
`default_nettype none
module vgs_fifo #(
   parameter int W = 19
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   input  wire logic         pop,
   output logic [W-1:0]      head,
   output logic              full,
   output logic              empty
);
   localparam int DEPTH = 2;
   localparam int PW = $clog2(DEPTH);

   logic [W-1:0]  slot_ff [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]   cnt_ff, cnt_in;

   assign head  = slot_ff[rp_ff];
   assign full  = (cnt_ff == (PW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/vgs_front.sv =====
// Front of the smoother: accepts words, writes voxels to the history store
// and issues one job per result. Depends on vgs_pkg.
`default_nettype none
module vgs_front #(
   parameter int AW = 18,
   parameter int TW = 31,
   parameter int LGW = 19,
   parameter int HIST_DEPTH = 131587
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        restart,
   input  wire logic                        busy,
   input  wire logic [TW-1:0]               total,
   input  wire logic [LGW-1:0]              lag,
   input  wire logic                        req_valid,
   input  wire logic                        req_opcode,
   input  wire logic [vgs_pkg::VOX_W-1:0]   req_voxel,
   output logic                             req_ready,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic [vgs_pkg::VOX_W-1:0]        wr_data,
   output logic                             push,
   output logic [AW:0]                      push_data,
   input  wire logic                        q_full,
   input  wire logic                        q_empty,
   input  wire logic                        back_idle
);
   logic [AW-1:0] in_cnt_ff, in_cnt_in, iss_addr_ff, iss_addr_in;
   logic [TW-1:0] rcv_ff, rcv_in, iss_ff, iss_in, diff;
   logic          end_pend_ff, end_pend_in;
   logic          acc, data_ok, push_last;

   assign req_ready = !q_full && !busy && !end_pend_ff;
   assign acc       = req_valid && req_ready;
   assign data_ok   = acc && (req_opcode == vgs_pkg::OP_VOXEL) && (rcv_ff < total);
   assign diff      = rcv_ff - iss_ff;
   assign push      = (data_ok && (diff >= TW'(lag)))
                   || (acc && (req_opcode == vgs_pkg::OP_DRAIN)
                       && (rcv_ff == total) && (iss_ff < total));
   assign push_last = (iss_ff + 1'b1 == total);
   assign push_data = {push_last, iss_addr_ff};

   assign wr_en   = data_ok;
   assign wr_addr = in_cnt_ff;
   assign wr_data = req_voxel;

   always_comb begin
      in_cnt_in   = in_cnt_ff;
      rcv_in      = rcv_ff;
      iss_in      = iss_ff;
      iss_addr_in = iss_addr_ff;
      end_pend_in = end_pend_ff && !(q_empty && back_idle);
      if (restart) begin
         in_cnt_in   = '0;
         rcv_in      = '0;
         iss_in      = '0;
         iss_addr_in = '0;
         end_pend_in = 1'b0;
      end else begin
         if (data_ok) begin
            in_cnt_in = (in_cnt_ff == AW'(HIST_DEPTH - 1)) ? '0 : in_cnt_ff + 1'b1;
            rcv_in    = rcv_ff + 1'b1;
         end
         if (push) begin
            if (push_last) begin
               // The volume is complete; hold off until the back has read its last window.
               in_cnt_in   = '0;
               rcv_in      = '0;
               iss_in      = '0;
               iss_addr_in = '0;
               end_pend_in = 1'b1;
            end else begin
               iss_in      = iss_ff + 1'b1;
               iss_addr_in = (iss_addr_ff == AW'(HIST_DEPTH - 1)) ? '0 : iss_addr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff   <= '0;
         rcv_ff      <= '0;
         iss_ff      <= '0;
         iss_addr_ff <= '0;
         end_pend_ff <= 1'b0;
      end else begin
         in_cnt_ff   <= in_cnt_in;
         rcv_ff      <= rcv_in;
         iss_ff      <= iss_in;
         iss_addr_ff <= iss_addr_in;
         end_pend_ff <= end_pend_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/vgs_back.sv =====
// Back of the smoother: holds the voxel history, walks the 27 neighbours of
// each job through a read pipeline, divides and registers the result word.
// Depends on vgs_pkg.
`default_nettype none
module vgs_back #(
   parameter int SXW = 9,
   parameter int SYW = 9,
   parameter int SZW = 13,
   parameter int PLW = 18,
   parameter int AW = 18,
   parameter int HIST_DEPTH = 131587
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        restart,
   input  wire logic [SXW-1:0]              xs,
   input  wire logic [SYW-1:0]              ys,
   input  wire logic [SZW-1:0]              zs,
   input  wire logic [PLW-1:0]              plane,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [vgs_pkg::VOX_W-1:0]   wr_data,
   input  wire logic                        job_valid,
   input  wire logic [AW:0]                 job,
   output logic                             pop,
   output logic                             idle,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [vgs_pkg::VOX_W-1:0]        rsp_smoothed,
   output logic                             rsp_last
);
   localparam int OFW = PLW + 2;
   localparam int SW  = AW + OFW;
   localparam logic signed [SW-1:0] HD_S = SW'(HIST_DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_FLUSH = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [vgs_pkg::VOX_W-1:0] hist [HIST_DEPTH];

   logic [2:0]     st_ff, st_in;
   logic [1:0]     ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;
   logic [AW-1:0]  ca_ff, ca_in;
   logic           jlast_ff, jlast_in;
   logic [SXW-1:0] px_ff, px_in;
   logic [SYW-1:0] py_ff, py_in;
   logic [SZW-1:0] pz_ff, pz_in;

   // Read pipeline: offset, address, memory data, product.
   logic                          a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   logic                          a_inb_ff, b_inb_ff, c_inb_ff, d_inb_ff;
   logic [1:0]                    a_d2_ff;
   logic [vgs_pkg::WT_W-1:0]      b_w_ff, c_w_ff, d_w_ff;
   logic signed [OFW-1:0]         a_off_ff, a_off_in;
   logic [AW-1:0]                 b_addr_ff, b_addr_in;
   logic [vgs_pkg::VOX_W-1:0]     c_data_ff;
   logic [vgs_pkg::PROD_W-1:0]    d_prod_ff;
   logic                          step, inb, bx, by, bz;
   logic [1:0]                    d2;
   logic signed [OFW-1:0]         zt, yt, xt;
   logic signed [SW-1:0]          sum;

   logic [vgs_pkg::ACC_W-1:0]     acc_ff, acc_in, rem_ff, rem_in;
   logic [vgs_pkg::WSUM_W-1:0]    wsum_ff, wsum_in;
   logic [vgs_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [vgs_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [vgs_pkg::QCNT_W-1:0]    qc_ff, qc_in;
   logic                          pipe_busy, load;
   logic                          ov_ff, ov_in;
   logic [vgs_pkg::VOX_W-1:0]     os_ff, os_in;
   logic                          ol_ff, ol_in;

   assign idle         = (st_ff == ST_IDLE);
   assign pop          = idle && job_valid;
   assign step         = (st_ff == ST_RUN);
   assign pipe_busy    = a_vld_ff || b_vld_ff || c_vld_ff || d_vld_ff;
   assign load         = (st_ff == ST_DONE) && (!ov_ff || rsp_ready);
   assign rsp_valid    = ov_ff;
   assign rsp_smoothed = os_ff;
   assign rsp_last     = ol_ff;

   // Neighbour classification for the current step.
   always_comb begin
      bx = (ix_ff == 2'd0) ? (px_ff != '0)
         : (ix_ff == 2'd2) ? (({1'b0, px_ff} + 1'b1) < {1'b0, xs}) : 1'b1;
      by = (iy_ff == 2'd0) ? (py_ff != '0)
         : (iy_ff == 2'd2) ? (({1'b0, py_ff} + 1'b1) < {1'b0, ys}) : 1'b1;
      bz = (iz_ff == 2'd0) ? (pz_ff != '0)
         : (iz_ff == 2'd2) ? (({1'b0, pz_ff} + 1'b1) < {1'b0, zs}) : 1'b1;
      inb = bx && by && bz;
      d2  = 2'(ix_ff != 2'd1) + 2'(iy_ff != 2'd1) + 2'(iz_ff != 2'd1);
      zt  = (iz_ff == 2'd0) ? -$signed({2'b00, plane})
          : (iz_ff == 2'd2) ? $signed({2'b00, plane}) : '0;
      yt  = (iy_ff == 2'd0) ? -$signed(OFW'(xs))
          : (iy_ff == 2'd2) ? $signed(OFW'(xs)) : '0;
      xt  = (ix_ff == 2'd0) ? -$signed(OFW'(1))
          : (ix_ff == 2'd2) ? $signed(OFW'(1)) : '0;
      a_off_in = zt + yt + xt;
   end

   // Neighbour address modulo the history depth.
   always_comb begin
      sum = $signed({{(SW-AW){1'b0}}, ca_ff}) + SW'(a_off_ff);
      if (sum < 0) begin
         b_addr_in = AW'(sum + HD_S);
      end else if (sum >= HD_S) begin
         b_addr_in = AW'(sum - HD_S);
      end else begin
         b_addr_in = AW'(sum);
      end
   end

   always_comb begin
      st_in    = st_ff;
      ix_in    = ix_ff;
      iy_in    = iy_ff;
      iz_in    = iz_ff;
      ca_in    = ca_ff;
      jlast_in = jlast_ff;
      acc_in   = acc_ff;
      wsum_in  = wsum_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      qc_in    = qc_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pz_in    = pz_ff;
      ov_in    = ov_ff && !rsp_ready;
      os_in    = os_ff;
      ol_in    = ol_ff;
      if (d_vld_ff && d_inb_ff) begin
         acc_in  = acc_ff + vgs_pkg::ACC_W'(d_prod_ff);
         wsum_in = wsum_ff + vgs_pkg::WSUM_W'(d_w_ff);
      end
      unique case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               ca_in    = job[AW-1:0];
               jlast_in = job[AW];
               ix_in    = '0;
               iy_in    = '0;
               iz_in    = '0;
               acc_in   = '0;
               wsum_in  = '0;
               st_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (ix_ff == 2'd2) begin
               ix_in = '0;
               if (iy_ff == 2'd2) begin
                  iy_in = '0;
                  iz_in = iz_ff + 1'b1;
                  if (iz_ff == 2'd2) begin
                     st_in = ST_FLUSH;
                  end
               end else begin
                  iy_in = iy_ff + 1'b1;
               end
            end else begin
               ix_in = ix_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!pipe_busy) begin
               rem_in = acc_ff;
               den_in = {wsum_ff, {(vgs_pkg::QUO_W-1){1'b0}}};
               quo_in = '0;
               qc_in  = '0;
               st_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit a cycle.
            if (rem_ff >= vgs_pkg::ACC_W'(den_ff)) begin
               rem_in = rem_ff - vgs_pkg::ACC_W'(den_ff);
               quo_in = {quo_ff[vgs_pkg::QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[vgs_pkg::QUO_W-2:0], 1'b0};
            end
            den_in = den_ff >> 1;
            qc_in  = qc_ff + 1'b1;
            if (qc_ff == vgs_pkg::QCNT_W'(vgs_pkg::QUO_W - 1)) begin
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               ov_in = 1'b1;
               os_in = quo_ff;
               ol_in = jlast_ff;
               st_in = ST_IDLE;
               if (jlast_ff) begin
                  px_in = '0;
                  py_in = '0;
                  pz_in = '0;
               end else if (({1'b0, px_ff} + 1'b1) == {1'b0, xs}) begin
                  px_in = '0;
                  if (({1'b0, py_ff} + 1'b1) == {1'b0, ys}) begin
                     py_in = '0;
                     pz_in = pz_ff + 1'b1;
                  end else begin
                     py_in = py_ff + 1'b1;
                  end
               end else begin
                  px_in = px_ff + 1'b1;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (restart) begin
         px_in = '0;
         py_in = '0;
         pz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         ov_ff    <= 1'b0;
         px_ff    <= '0;
         py_ff    <= '0;
         pz_ff    <= '0;
      end else begin
         st_ff    <= st_in;
         a_vld_ff <= step;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         ov_ff    <= ov_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
      end
   end

   always_ff @(posedge clock) begin
      ix_ff     <= ix_in;
      iy_ff     <= iy_in;
      iz_ff     <= iz_in;
      ca_ff     <= ca_in;
      jlast_ff  <= jlast_in;
      acc_ff    <= acc_in;
      wsum_ff   <= wsum_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      qc_ff     <= qc_in;
      os_ff     <= os_in;
      ol_ff     <= ol_in;
      a_off_ff  <= a_off_in;
      a_inb_ff  <= inb;
      a_d2_ff   <= d2;
      b_addr_ff <= b_addr_in;
      b_inb_ff  <= a_inb_ff;
      b_w_ff    <= vgs_pkg::gauss_weight(a_d2_ff);
      c_inb_ff  <= b_inb_ff;
      c_w_ff    <= b_w_ff;
      d_inb_ff  <= c_inb_ff;
      d_w_ff    <= c_w_ff;
      d_prod_ff <= vgs_pkg::PROD_W'(c_data_ff) * vgs_pkg::PROD_W'(c_w_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist[wr_addr] <= wr_data;
      end
      c_data_ff <= hist[b_addr_ff];
   end
endmodule
`default_nettype wire

// ===== rtl/volume_gauss_3x3x3_smoother.sv =====
// 3x3x3 Gaussian smoother: the front takes one word a cycle while its two-entry job queue
// has room, the sizes have settled and no finished volume waits on the back. The back works
// on one job at a time: it takes the job, makes 27 history reads, drains the four-stage read
// pipeline, runs the divider and loads the result register. A result leaves one plane plus
// one row plus one voxel behind its voxel. Reset is synchronous; words are refused after
// reset or a size write until the sizes have settled. History is not cleared.
`default_nettype none
module volume_gauss_3x3x3_smoother #(
   parameter int MAX_ROW  = vgs_pkg::DEF_MAX_ROW,
   parameter int MAX_ROWS = vgs_pkg::DEF_MAX_ROWS
) (
   input  wire logic clock,
   input  wire logic reset,
   vgs_req_if.sink   req_ch,
   vgs_rsp_if.source rsp_ch,
   vgs_csr_if.sink   csr_ch
);
   localparam int SXW = $clog2(MAX_ROW + 1);
   localparam int SYW = $clog2(MAX_ROWS + 1);
   localparam int SZW = vgs_pkg::Z_W;
   localparam int PLW = SXW + SYW;
   localparam int TW  = PLW + SZW;
   localparam int LGW = PLW + 1;
   // Two planes, two rows and three voxels of window, plus one voxel for each queued job,
   // since the front may write that far ahead of the window being read.
   localparam int HIST_DEPTH = 2 * MAX_ROW * MAX_ROWS + 2 * MAX_ROW + 5;
   localparam int AW  = $clog2(HIST_DEPTH);

   logic [vgs_pkg::XREG_W-1:0] xreg_ff;
   logic [vgs_pkg::YREG_W-1:0] yreg_ff;
   logic [vgs_pkg::ZREG_W-1:0] zreg_ff;
   logic [SXW-1:0] xs_in, xs_ff;
   logic [SYW-1:0] ys_in, ys_ff;
   logic [SZW-1:0] zs_in, zs_ff;
   logic [PLW-1:0] plane_ff;
   logic [TW-1:0]  total_ff;
   logic [LGW-1:0] lag_ff;
   logic [1:0]     settle_ff;
   logic           csr_acc, restart;

   logic          wr_en, push, pop, q_full, q_empty, back_idle;
   logic [AW-1:0] wr_addr;
   logic [vgs_pkg::VOX_W-1:0] wr_data;
   logic [AW:0]   push_data, head;

   assign csr_ch.ready = 1'b1;
   assign csr_acc = csr_ch.valid && csr_ch.ready;
   assign restart = csr_acc && ((csr_ch.index == vgs_pkg::REG_X_SIZE)
                             || (csr_ch.index == vgs_pkg::REG_Y_SIZE)
                             || (csr_ch.index == vgs_pkg::REG_Z_SIZE));

   always_ff @(posedge clock) begin
      if (reset) begin
         xreg_ff   <= vgs_pkg::RST_X_SIZE;
         yreg_ff   <= vgs_pkg::RST_Y_SIZE;
         zreg_ff   <= vgs_pkg::RST_Z_SIZE;
         settle_ff <= 2'd3;
      end else begin
         if (restart) begin
            settle_ff <= 2'd3;
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 1'b1;
         end
         if (csr_acc) begin
            priority if (csr_ch.index == vgs_pkg::REG_X_SIZE) begin
               xreg_ff <= csr_ch.data[vgs_pkg::XREG_W-1:0];
            end else if (csr_ch.index == vgs_pkg::REG_Y_SIZE) begin
               yreg_ff <= csr_ch.data[vgs_pkg::YREG_W-1:0];
            end else if (csr_ch.index == vgs_pkg::REG_Z_SIZE) begin
               zreg_ff <= csr_ch.data;
            end else begin
               xreg_ff <= xreg_ff;
            end
         end
      end
   end

   // Zero counts as one, anything above the limit as the limit.
   always_comb begin
      if (xreg_ff == '0) xs_in = SXW'(1);
      else if (32'(xreg_ff) > MAX_ROW) xs_in = SXW'(MAX_ROW);
      else xs_in = SXW'(xreg_ff);
      if (yreg_ff == '0) ys_in = SYW'(1);
      else if (32'(yreg_ff) > MAX_ROWS) ys_in = SYW'(MAX_ROWS);
      else ys_in = SYW'(yreg_ff);
      if (zreg_ff == '0) zs_in = SZW'(1);
      else if (32'(zreg_ff) > vgs_pkg::Z_LIMIT) zs_in = SZW'(vgs_pkg::Z_LIMIT);
      else zs_in = SZW'(zreg_ff);
   end

   always_ff @(posedge clock) begin
      xs_ff    <= xs_in;
      ys_ff    <= ys_in;
      zs_ff    <= zs_in;
      plane_ff <= PLW'(xs_ff) * PLW'(ys_ff);
      total_ff <= TW'(plane_ff) * TW'(zs_ff);
      lag_ff   <= LGW'(plane_ff) + LGW'(xs_ff) + 1'b1;
   end

   vgs_front #(
      .AW(AW), .TW(TW), .LGW(LGW), .HIST_DEPTH(HIST_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .busy       (settle_ff != 2'd0),
      .total      (total_ff),
      .lag        (lag_ff),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_voxel  (req_ch.voxel),
      .req_ready  (req_ch.ready),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .push       (push),
      .push_data  (push_data),
      .q_full     (q_full),
      .q_empty    (q_empty),
      .back_idle  (back_idle)
   );

   vgs_fifo #(.W(AW + 1)) u_fifo (
      .clock     (clock),
      .reset     (reset || restart),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   vgs_back #(
      .SXW(SXW), .SYW(SYW), .SZW(SZW), .PLW(PLW), .AW(AW), .HIST_DEPTH(HIST_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .xs           (xs_ff),
      .ys           (ys_ff),
      .zs           (zs_ff),
      .plane        (plane_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .job_valid    (!q_empty),
      .job          (head),
      .pop          (pop),
      .idle         (back_idle),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_smoothed (rsp_ch.smoothed),
      .rsp_last     (rsp_ch.last_voxel)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_full || pop))
      else $error("job queue overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("job taken from an empty queue");

   a_settle_block: assert property (@(posedge clock) disable iff (reset)
      restart |=> !req_ch.ready)
      else $error("word accepted before sizes settled");
endmodule
`default_nettype wire

// ===== bench/volume_gauss_3x3x3_smoother_tb.sv =====
// Self-checking testbench of the 3x3x3 Gaussian volume smoother.
// Depends on vgs_pkg, the channel interfaces in vgs_if and the block itself.
`timescale 1ns / 1ps
`default_nettype none
module volume_gauss_3x3x3_smoother_tb;
   localparam int ROW_LIMIT   = 256;
   localparam int PLANE_LIMIT = 256;
   localparam int SETTLE_CYC  = 120;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int ITEM_TARGET = 1050;

   typedef enum logic {JOB_WORD, JOB_CSR} job_kind_type;

   typedef struct {
      job_kind_type                   kind;
      logic                           opcode;
      logic [vgs_pkg::VOX_W-1:0]      voxel;
      logic [vgs_pkg::CSR_IDX_W-1:0]  index;
      logic [vgs_pkg::CSR_DATA_W-1:0] data;
   } job_type;

   typedef struct {
      logic [vgs_pkg::VOX_W-1:0] smoothed;
      logic                      last_voxel;
   } smoothed_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vgs_req_if req_ch ();
   vgs_rsp_if rsp_ch ();
   vgs_csr_if csr_ch ();

   volume_gauss_3x3x3_smoother dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   job_type      pending_jobs[$];
   smoothed_type expected_voxels[$];
   int unsigned errors = 0;
   int unsigned results_checked = 0;
   int unsigned volumes_queued = 0;
   int unsigned words_queued = 0;
   int unsigned cycle_count = 0;

   // Predictor state: raw size registers, voxels of the current volume by linear index.
   logic [vgs_pkg::XREG_W-1:0] x_reg = vgs_pkg::RST_X_SIZE;
   logic [vgs_pkg::YREG_W-1:0] y_reg = vgs_pkg::RST_Y_SIZE;
   logic [vgs_pkg::ZREG_W-1:0] z_reg = vgs_pkg::RST_Z_SIZE;
   logic [vgs_pkg::VOX_W-1:0]  volume_mem[int unsigned];
   int unsigned       received = 0;
   int unsigned       pos_x = 0, pos_y = 0, pos_z = 0;

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint unsigned axis_weight(input int unsigned off_axes);
      case (off_axes)
         0: return 65535;
         1: return 55524;
         2: return 47041;
         default: return 39855;
      endcase
   endfunction

   function automatic void restart_volume();
      received = 0;
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
      volume_mem.delete();
   endfunction

   function automatic void smooth_next(input int unsigned xs, input int unsigned ys,
                                       input int unsigned zs);
      longint unsigned acc, wsum, w, q;
      int x, y, z;
      smoothed_type r;
      acc = 0;
      wsum = 0;
      for (int dz = -1; dz <= 1; dz++) begin
         z = int'(pos_z) + dz;
         if (z < 0 || z >= int'(zs)) continue;
         for (int dy = -1; dy <= 1; dy++) begin
            y = int'(pos_y) + dy;
            if (y < 0 || y >= int'(ys)) continue;
            for (int dx = -1; dx <= 1; dx++) begin
               x = int'(pos_x) + dx;
               if (x < 0 || x >= int'(xs)) continue;
               w = axis_weight((dx != 0) + (dy != 0) + (dz != 0));
               acc += longint'(volume_mem[x + xs * (y + ys * z)]) * w;
               wsum += w;
            end
         end
      end
      q = acc / wsum;
      r.smoothed = (q > 255) ? 8'd255 : q[7:0];
      r.last_voxel = (pos_x + 1 == xs) && (pos_y + 1 == ys) && (pos_z + 1 == zs);
      expected_voxels.push_back(r);
      if (r.last_voxel) begin
         restart_volume();
      end else if (++pos_x >= xs) begin
         pos_x = 0;
         if (++pos_y >= ys) begin
            pos_y = 0;
            pos_z++;
         end
      end
   endfunction

   function automatic void predict_word(input logic op, input logic [vgs_pkg::VOX_W-1:0] v);
      int unsigned xs, ys, zs, total, lag, done;
      xs = clamp_dim(x_reg, ROW_LIMIT);
      ys = clamp_dim(y_reg, PLANE_LIMIT);
      zs = clamp_dim(z_reg, vgs_pkg::Z_LIMIT);
      total = xs * ys * zs;
      lag = xs * ys + xs + 1;
      done = pos_x + xs * (pos_y + ys * pos_z);
      if (op == vgs_pkg::OP_VOXEL) begin
         if (received >= total) return;
         volume_mem[received] = v;
         received++;
         if (received - done > lag) smooth_next(xs, ys, zs);
      end else if (received == total && done < total) begin
         smooth_next(xs, ys, zs);
      end
   endfunction

   function automatic void write_size(input logic [vgs_pkg::CSR_IDX_W-1:0] idx,
                                      input logic [vgs_pkg::CSR_DATA_W-1:0] d);
      case (idx)
         vgs_pkg::REG_X_SIZE: x_reg = d[vgs_pkg::XREG_W-1:0];
         vgs_pkg::REG_Y_SIZE: y_reg = d[vgs_pkg::YREG_W-1:0];
         vgs_pkg::REG_Z_SIZE: z_reg = d[vgs_pkg::ZREG_W-1:0];
         default: return;
      endcase
      restart_volume();
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      errors++;
   endtask

   // Acceptance, prediction and checking all happen at the rising edge.
   logic req_took = 1'b0;
   logic csr_took = 1'b0;
   always @(posedge clock) begin
      smoothed_type e;
      cycle_count <= cycle_count + 1;
      req_took <= req_ch.valid && req_ch.ready;
      csr_took <= csr_ch.valid && csr_ch.ready;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_voxels.size() == 0) begin
               report_mismatch("unexpected word, smoothed", rsp_ch.smoothed, -1);
            end else begin
               e = expected_voxels.pop_front();
               results_checked++;
               if (rsp_ch.smoothed !== e.smoothed)
                  report_mismatch("smoothed", rsp_ch.smoothed, e.smoothed);
               if (rsp_ch.last_voxel !== e.last_voxel)
                  report_mismatch("last_voxel", rsp_ch.last_voxel, e.last_voxel);
            end
         end
         if (csr_ch.valid && csr_ch.ready) write_size(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) predict_word(req_ch.opcode, req_ch.voxel);
      end
   end

   // Mostly short gaps, a few long ones, and quiet stretches with none.
   function automatic int pick_gap(input logic quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   int   word_gap = 0, rsp_stall = 0, settle = 0;
   logic quiet_in = 1'b0, quiet_out = 1'b0;
   always @(negedge clock) begin
      logic nreq, ncsr;
      job_type j;
      if (!reset) begin
         if ($urandom_range(0, 149) == 0) quiet_in = ~quiet_in;
         if ($urandom_range(0, 149) == 0) quiet_out = ~quiet_out;
         if ((!req_ch.valid || req_took) && (!csr_ch.valid || csr_took)) begin
            nreq = 1'b0;
            ncsr = 1'b0;
            if (word_gap > 0) begin
               word_gap--;
            end else if (pending_jobs.size() > 0) begin
               if (pending_jobs[0].kind == JOB_CSR) begin
                  // Size writes wait until the block has gone quiet.
                  if (expected_voxels.size() != 0) begin
                     settle = 0;
                  end else if (settle < SETTLE_CYC) begin
                     settle++;
                  end else begin
                     j = pending_jobs.pop_front();
                     settle = 0;
                     ncsr = 1'b1;
                     csr_ch.index <= j.index;
                     csr_ch.data <= j.data;
                  end
               end else begin
                  j = pending_jobs.pop_front();
                  nreq = 1'b1;
                  req_ch.opcode <= j.opcode;
                  req_ch.voxel <= j.voxel;
                  word_gap = pick_gap(quiet_in);
               end
            end
            req_ch.valid <= nreq;
            csr_ch.valid <= ncsr;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_stall = pick_gap(quiet_out);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL volume_gauss_3x3x3_smoother");
         $finish;
      end
   end

   function automatic logic [vgs_pkg::VOX_W-1:0] pick_voxel();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return '0;
      if (r < 4) return '1;
      return $urandom_range(0, 255);
   endfunction

   function automatic void queue_word(input logic op, input logic [vgs_pkg::VOX_W-1:0] v);
      job_type j;
      j.kind = JOB_WORD;
      j.opcode = op;
      j.voxel = v;
      j.index = vgs_pkg::REG_X_SIZE;
      j.data = '0;
      pending_jobs.push_back(j);
      words_queued++;
   endfunction

   function automatic void queue_size(input logic [vgs_pkg::CSR_IDX_W-1:0] idx,
                                      input int unsigned d);
      job_type j;
      j.kind = JOB_CSR;
      j.opcode = vgs_pkg::OP_VOXEL;
      j.voxel = '0;
      j.index = idx;
      j.data = d[vgs_pkg::CSR_DATA_W-1:0];
      pending_jobs.push_back(j);
   endfunction

   // One volume: size writes, its voxels, then the drains that flush the tail.
   // With noise set, stray drains and surplus voxels are mixed in; a cut volume stops early.
   function automatic void queue_volume(input int unsigned xr, input int unsigned yr,
                                        input int unsigned zr, input logic noise,
                                        input logic cut, input int fill);
      int unsigned xs, ys, zs, total, lag, count;
      xs = clamp_dim(xr, ROW_LIMIT);
      ys = clamp_dim(yr, PLANE_LIMIT);
      zs = clamp_dim(zr, vgs_pkg::Z_LIMIT);
      total = xs * ys * zs;
      lag = xs * ys + xs + 1;
      queue_size(vgs_pkg::REG_X_SIZE, xr);
      queue_size(vgs_pkg::REG_Y_SIZE, yr);
      queue_size(vgs_pkg::REG_Z_SIZE, zr);
      volumes_queued++;
      count = cut ? $urandom_range(0, total - 1) : total;
      for (int unsigned i = 0; i < count; i++) begin
         if (noise && $urandom_range(0, 19) == 0) queue_word(vgs_pkg::OP_DRAIN, pick_voxel());
         queue_word(vgs_pkg::OP_VOXEL, (fill >= 0) ? fill[vgs_pkg::VOX_W-1:0] : pick_voxel());
      end
      if (cut) return;
      if (noise && $urandom_range(0, 3) == 0) queue_word(vgs_pkg::OP_VOXEL, pick_voxel());
      for (int unsigned i = 0; i < ((total < lag) ? total : lag); i++)
         queue_word(vgs_pkg::OP_DRAIN, pick_voxel());
      if (noise && $urandom_range(0, 3) == 0) queue_word(vgs_pkg::OP_DRAIN, pick_voxel());
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = vgs_pkg::OP_VOXEL;
      req_ch.voxel = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = vgs_pkg::REG_X_SIZE;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;

      // Directed: zero sizes count as one, a drain with nothing in progress,
      // a saturated cube, a dark line, surplus and stray words.
      queue_word(vgs_pkg::OP_DRAIN, 8'hFF);
      queue_volume(0, 0, 0, 1'b0, 1'b0, 255);
      queue_word(vgs_pkg::OP_DRAIN, 8'h00);
      queue_volume(2, 2, 2, 1'b0, 1'b0, 255);
      queue_volume(3, 1, 1, 1'b0, 1'b0, 0);
      queue_word(vgs_pkg::OP_VOXEL, 8'hAA);
      queue_word(vgs_pkg::OP_DRAIN, 8'h55);
      // A row longer than the limit, then a small stack of three planes.
      queue_volume(511, 1, 1, 1'b0, 1'b0, -1);
      queue_volume(2, 2, 3, 1'b0, 1'b0, -1);

      // Random volumes, mostly small, with occasional cut-off and noisy ones.
      while (words_queued < ITEM_TARGET) begin
         queue_volume($urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(0, 5),
                      $urandom_range(0, 3) == 0, $urandom_range(0, 14) == 0, -1);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_jobs.size() != 0 || req_ch.valid || csr_ch.valid ||
             expected_voxels.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (expected_voxels.size() != 0) begin
         $display("%0d expected words never arrived", expected_voxels.size());
         errors++;
      end
      $display("%0d volumes, %0d input words, %0d smoothed words checked, %0d errors",
               volumes_queued, words_queued, results_checked, errors);
      if (errors == 0) begin
         $display("PASS volume_gauss_3x3x3_smoother");
      end else begin
         $display("FAIL volume_gauss_3x3x3_smoother");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/vgs_pkg.sv
rtl/vgs_if.sv
rtl/vgs_fifo.sv
rtl/vgs_front.sv
rtl/vgs_back.sv
rtl/volume_gauss_3x3x3_smoother.sv
bench/volume_gauss_3x3x3_smoother_tb.sv
